// ===== hw/rtl/running_sum_moving_average_core_defines.svh =====
// Assertion macros shared by the moving average core.
// No dependencies; included by the top level only.
`ifndef RUNNING_SUM_MOVING_AVERAGE_CORE_DEFINES_SVH
`define RUNNING_SUM_MOVING_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication
`define RSMA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RSMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rsma_pkg.sv =====
// Package for the moving average core: back end states, register map, constants.
// No dependencies.
`default_nettype none
package rsma_pkg;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_DIVIDE
  } back_state_t;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // register index taken from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  localparam int WINDOW_RESET = 11;

  localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

// ===== hw/rtl/rsma_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module rsma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rsma_queue.sv =====
// Short FIFO between the accepting front and the filter back end.
// Depends on nothing but its parameters.
`default_nettype none
module rsma_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_BITS'(DEPTH));
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rsma_div.sv =====
// Bit-serial signed by unsigned divider, truncating toward zero.
// One quotient bit per cycle; no dependencies.
`default_nettype none
module rsma_div #(
  parameter int NUM_BITS = 22,
  parameter int DEN_BITS = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [NUM_BITS-1:0] dividend,
  input  wire logic        [DEN_BITS-1:0] divisor,
  output logic                            busy,
  output logic signed      [NUM_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [CNT_BITS-1:0] count;
  logic                neg;
  logic [NUM_BITS-1:0] quo;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  assign trial    = {rem, quo[NUM_BITS-1]};
  assign fits     = (trial >= {1'b0, den});
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[NUM_BITS-1];
      quo <= dividend[NUM_BITS-1] ? NUM_BITS'(-dividend) : NUM_BITS'(dividend);
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? DEN_BITS'(trial - {1'b0, den}) : trial[DEN_BITS-1:0];
      quo <= {quo[NUM_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_BITS'(NUM_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rsma_back.sv =====
// Filter back end: ring read, running sum update, division and result register.
// Depends on rsma_pkg, rsma_ram and rsma_div.
`default_nettype none
module rsma_back #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int LEN_BITS    = 7,
  parameter int IDX_BITS    = 6,
  parameter int SUM_BITS    = 22
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          restart,
  input  wire logic        [LEN_BITS-1:0]    eff_len,
  input  wire logic                          q_empty,
  input  wire logic signed [SAMPLE_BITS-1:0] q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [SAMPLE_BITS-1:0] out_average,
  output logic                               out_full
);

  rsma_pkg::back_state_t state;
  rsma_pkg::back_state_t state_next;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic        [IDX_BITS-1:0]    leave_idx;
  logic        [IDX_BITS:0]      leave_wide;
  logic        [IDX_BITS-1:0]    leave_calc;
  logic        [IDX_BITS-1:0]    pos;
  logic        [LEN_BITS-1:0]    seen;
  logic        [LEN_BITS-1:0]    seen_next;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SUM_BITS-1:0]    sum_next;
  logic        [WINDOW_MAX-1:0]  valid;
  logic                          full_flag;
  logic signed [SAMPLE_BITS-1:0] leaving;
  logic        [SAMPLE_BITS-1:0] ram_rd_data;
  logic                          ram_rd_en;
  logic                          ram_wr_en;
  logic                          div_start;
  logic                          div_busy;
  logic signed [SUM_BITS-1:0]    div_quotient;
  logic                          emit;

  assign leave_wide = (IDX_BITS + 1)'(pos) + (IDX_BITS + 1)'(WINDOW_MAX)
                      - (IDX_BITS + 1)'(eff_len);
  assign leave_calc = (leave_wide >= (IDX_BITS + 1)'(WINDOW_MAX))
                      ? IDX_BITS'(leave_wide - (IDX_BITS + 1)'(WINDOW_MAX))
                      : leave_wide[IDX_BITS-1:0];

  assign leaving   = valid[leave_idx] ? $signed(ram_rd_data) : '0;
  assign sum_next  = sum + SUM_BITS'(sample) - SUM_BITS'(leaving);
  assign seen_next = (seen < LEN_BITS'(WINDOW_MAX)) ? seen + 1'b1 : seen;

  rsma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (pos),
    .wr_data (sample),
    .rd_en   (ram_rd_en),
    .rd_addr (leave_calc),
    .rd_data (ram_rd_data)
  );

  rsma_div #(
    .NUM_BITS (SUM_BITS),
    .DEN_BITS (LEN_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (eff_len),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      rsma_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_next = rsma_pkg::BK_UPDATE;
        end
      end
      rsma_pkg::BK_UPDATE: begin
        state_next = rsma_pkg::BK_DIVIDE;
      end
      rsma_pkg::BK_DIVIDE: begin
        if (!div_busy && (!out_valid || out_ready)) begin
          state_next = rsma_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = rsma_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_rd_en = 1'b0;
    ram_wr_en = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state)
      rsma_pkg::BK_IDLE: begin
        q_pop     = !q_empty;
        ram_rd_en = !q_empty;
      end
      rsma_pkg::BK_UPDATE: begin
        ram_wr_en = 1'b1;
        div_start = 1'b1;
      end
      rsma_pkg::BK_DIVIDE: begin
        emit = !div_busy && (!out_valid || out_ready);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == rsma_pkg::BK_IDLE) begin
      sample    <= q_data;
      leave_idx <= leave_calc;
    end
    if (emit) begin
      out_average <= div_quotient[SAMPLE_BITS-1:0];
      out_full    <= full_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state     <= rsma_pkg::BK_IDLE;
      pos       <= '0;
      seen      <= '0;
      sum       <= '0;
      valid     <= '0;
      full_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rsma_pkg::BK_UPDATE) begin
        sum        <= sum_next;
        valid[pos] <= 1'b1;
        pos        <= (pos == IDX_BITS'(WINDOW_MAX - 1)) ? '0 : pos + 1'b1;
        seen       <= seen_next;
        full_flag  <= (seen_next >= eff_len);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/running_sum_moving_average_core.sv =====
// Top level of the running sum moving average core: APB register, input queue, back end.
// Depends on rsma_pkg, rsma_queue, rsma_back and the assertion macro header.
//
//   channel   kind          contents
//   s_*       stream in     tdata[SAMPLE_BITS-1:0] sample_in
//   m_*       stream out    tdata[SAMPLE_BITS-1:0] average_out, tuser[0] window_full
//   p*        APB           0x0 window_length (write restarts the filter)
//
// Each sample passes the back end states idle, update and divide; the divide state
// waits on the bit-serial divider, which yields one quotient bit per cycle.
// A two-entry queue takes samples while the back end works; the result register
// holds a finished average while the next sample is already being processed.
// Reset and window_length writes clear the ring at once through per-entry valid bits.
`default_nettype none
`include "running_sum_moving_average_core_defines.svh"
module running_sum_moving_average_core #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // [SAMPLE_BITS-1:0] sample_in
  input  wire logic [8*((SAMPLE_BITS+7)/8)-1:0]       s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // [SAMPLE_BITS-1:0] average_out
  output logic      [8*((SAMPLE_BITS+7)/8)-1:0]       m_tdata,
  // [0] window_full
  output logic      [0:0]                             m_tuser,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [rsma_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  wire logic [rsma_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic      [rsma_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                        pready
);

  localparam int TDATA_BITS = 8 * ((SAMPLE_BITS + 7) / 8);
  localparam int LEN_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int IDX_BITS   = $clog2(WINDOW_MAX);
  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX);

  logic [LEN_BITS-1:0]           window_length;
  logic [LEN_BITS-1:0]           eff_len;
  logic                          reg_sel;
  logic                          restart;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_empty;
  logic                          q_full;
  logic [SAMPLE_BITS-1:0]        q_data;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          window_full;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[rsma_pkg::APB_ADDR_BITS-1] == rsma_pkg::REG_WINDOW_LENGTH);
  assign restart = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? rsma_pkg::APB_DATA_BITS'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_BITS'(rsma_pkg::WINDOW_RESET);
    end else if (restart) begin
      window_length <= pwdata[LEN_BITS-1:0];
    end
  end

  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (window_length > LEN_BITS'(WINDOW_MAX)) begin
      eff_len = LEN_BITS'(WINDOW_MAX);
    end else begin
      eff_len = window_length;
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  rsma_queue #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (rsma_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (s_tdata[SAMPLE_BITS-1:0]),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  rsma_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_BITS    (LEN_BITS),
    .IDX_BITS    (IDX_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .eff_len     (eff_len),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_average (average),
    .out_full    (window_full)
  );

  assign m_tdata    = TDATA_BITS'($unsigned(average));
  assign m_tuser[0] = window_full;

  `RSMA_ASSERT_IMP(a_len_in_range, clk, rst, 1'b1, (eff_len != '0) && (eff_len <= LEN_BITS'(WINDOW_MAX)), "effective window length out of range")
  `RSMA_ASSERT_NEXT(a_accept_queued, clk, rst, s_tvalid && s_tready, !q_empty, "accepted sample not held in queue")
  `RSMA_ASSERT_IMP(a_pop_not_empty, clk, rst, q_pop, !q_empty, "queue popped while empty")

endmodule
`default_nettype wire
